// ===== hdl/lpcf_pkg.sv =====
// lpcf_pkg: shared types, codes and helpers for the LED panel chain frame store.
// Used by lpcf_map and led_panel_chain_framebuffer. No dependencies.
`default_nettype none
package lpcf_pkg;

  // Default geometry, handed to the top-level parameters
  localparam int PANEL_ROWS_DEF = 16;
  localparam int PANEL_COLS_DEF = 16;
  localparam int MAX_PANELS_DEF = 32;

  // Fixed field widths
  localparam int COLOR_W   = 24;
  localparam int POS_W     = 9;
  localparam int CNT_W     = 6;
  localparam int OMAP_W    = 64;
  localparam int OUT_ROW_W = 4;
  localparam int OUT_COL_W = 9;
  localparam int CFG_IDX_W = 2;

  // Reciprocal divide: exact quotient for 12-bit values by divisors up to 64
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 17;
  localparam int DIVIN_W     = 12;
  localparam int QUOT_W      = 11;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_FILL  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_COLOR     = 2'd0,
    REG_PANEL_COUNT    = 2'd1,
    REG_PANELS_PER_ROW = 2'd2,
    REG_ORIENTATION    = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    ROT_UP  = 2'd0,
    ROT_CW  = 2'd1,
    ROT_180 = 2'd2,
    ROT_CCW = 2'd3
  } orient_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MAP,
    ST_READ,
    ST_RESULT,
    ST_CLEAR,
    ST_FILL
  } state_t;

  // Handed from the mapper to the controller
  typedef struct packed {
    logic done;
    logic outside;
  } map_status_t;

  // floor(x / d) with m = ceil(2^RECIP_SHIFT / d)
  function automatic logic [QUOT_W-1:0] recip_div(input logic [DIVIN_W-1:0] x,
                                                  input logic [RECIP_W-1:0] m);
    logic [DIVIN_W+RECIP_W-1:0] p;
    p = (DIVIN_W+RECIP_W)'(x) * (DIVIN_W+RECIP_W)'(m);
    return p[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lpcf_ram.sv =====
// lpcf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lpcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/lpcf_map.sv =====
// lpcf_map: seven-stage pipeline that maps a chain or global pixel position to
// a store address, with the outside-of-chain check. Depends on lpcf_pkg.
`default_nettype none
module lpcf_map #(
  parameter int PANEL_ROWS = lpcf_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLS = lpcf_pkg::PANEL_COLS_DEF,
  parameter int MAX_PANELS = lpcf_pkg::MAX_PANELS_DEF,
  localparam int RW_W       = $clog2(PANEL_ROWS),
  localparam int CW_W       = $clog2(PANEL_COLS),
  localparam int CHAIN_COLS = PANEL_COLS * MAX_PANELS,
  localparam int BC_W       = $clog2(CHAIN_COLS),
  localparam int DEPTH      = PANEL_ROWS * CHAIN_COLS,
  localparam int AW         = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         raw,
  input  wire logic [lpcf_pkg::POS_W-1:0]   row,
  input  wire logic [lpcf_pkg::POS_W-1:0]   col,
  input  wire logic [lpcf_pkg::CNT_W-1:0]   panel_count,
  input  wire logic [lpcf_pkg::CNT_W-1:0]   panels_per_row,
  input  wire logic [lpcf_pkg::OMAP_W-1:0]  orientation_map,
  output lpcf_pkg::map_status_t             status,
  output logic      [RW_W-1:0]              brow,
  output logic      [BC_W-1:0]              bcol,
  output logic      [AW-1:0]                addr
);

  localparam int STAGES = 7;
  localparam int PN_W   = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;
  localparam int QW     = lpcf_pkg::QUOT_W;
  localparam int DW     = lpcf_pkg::DIVIN_W;
  localparam logic [lpcf_pkg::RECIP_W-1:0] RECIP_R =
    lpcf_pkg::RECIP_W'(((2 ** lpcf_pkg::RECIP_SHIFT) + PANEL_ROWS - 1) / PANEL_ROWS);
  localparam logic [lpcf_pkg::RECIP_W-1:0] RECIP_C =
    lpcf_pkg::RECIP_W'(((2 ** lpcf_pkg::RECIP_SHIFT) + PANEL_COLS - 1) / PANEL_COLS);

  // bit 0 marks the held word, bit k marks stage k loaded
  logic [STAGES:0] vld;

  // stage 1
  logic [QW-1:0] s1_qr, s1_qc;
  logic [12:0]   s1_rw;
  logic [lpcf_pkg::CNT_W-1:0] s1_pan;
  // stage 2
  logic [RW_W-1:0] s2_lr;
  logic [CW_W-1:0] s2_lc;
  logic [16:0]     s2_base;
  logic            s2_odd, s2_col_out, s2_chain_out;
  logic [DW-1:0]   s2_diff;
  logic [QW-1:0]   s2_qc;
  logic [lpcf_pkg::CNT_W-1:0] s2_pan;
  // stage 3
  logic [QW-1:0]   s3_qd, s3_qlc, s3_qlr, s3_qc;
  logic [RW_W-1:0] s3_lr;
  logic [CW_W-1:0] s3_lc;
  logic [16:0]     s3_base;
  logic            s3_odd, s3_col_out, s3_chain_out;
  logic [lpcf_pkg::CNT_W-1:0] s3_pan;
  // stage 4
  logic [16:0]     s4_panel;
  logic [RW_W-1:0] s4_lr, s4_lcr;
  logic [CW_W-1:0] s4_lc, s4_lrc;
  logic            s4_col_out, s4_chain_out;
  logic [lpcf_pkg::CNT_W-1:0] s4_pan;
  // stage 5
  logic [RW_W-1:0] s5_nr;
  logic [CW_W-1:0] s5_nc;
  logic [PN_W-1:0] s5_pidx;
  logic            s5_outside;
  // stage 6
  logic [RW_W-1:0] s6_brow;
  logic [BC_W-1:0] s6_bcol;
  logic            s6_outside;
  // stage 7
  logic            s7_outside;

  logic [15:0] lr_full, lc_full, lrc_full, lcr_full;
  logic [12:0] diff_full;
  logic [PN_W-1:0] pidx;
  lpcf_pkg::orient_t orient;
  logic [RW_W-1:0] nr;
  logic [CW_W-1:0] nc;
  logic outside_g;

  assign lr_full   = 16'(row) - 16'(s1_qr) * 16'(PANEL_ROWS);
  assign lc_full   = 16'(col) - 16'(s1_qc) * 16'(PANEL_COLS);
  assign diff_full = s1_rw - 13'(col) - 13'd1;
  assign lrc_full  = 16'(s3_lr) - 16'(s3_qlc) * 16'(PANEL_COLS);
  assign lcr_full  = 16'(s3_lc) - 16'(s3_qlr) * 16'(PANEL_ROWS);

  // rotation by the panel's orientation
  assign pidx      = s4_panel[PN_W-1:0];
  assign orient    = lpcf_pkg::orient_t'(orientation_map[{pidx, 1'b0} +: 2]);
  assign outside_g = s4_col_out || (s4_panel >= 17'(s4_pan));

  always_comb begin
    unique case (orient)
      lpcf_pkg::ROT_CW: begin
        nr = s4_lcr;
        nc = CW_W'(PANEL_COLS - 1) - s4_lrc;
      end
      lpcf_pkg::ROT_180: begin
        nr = RW_W'(PANEL_ROWS - 1) - s4_lr;
        nc = CW_W'(PANEL_COLS - 1) - s4_lc;
      end
      lpcf_pkg::ROT_CCW: begin
        nr = RW_W'(PANEL_ROWS - 1) - s4_lcr;
        nc = s4_lrc;
      end
      default: begin
        nr = s4_lr;
        nc = s4_lc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: quotients of row and column by the panel size
    s1_qr  <= lpcf_pkg::recip_div(DW'(row), RECIP_R);
    s1_qc  <= lpcf_pkg::recip_div(DW'(col), RECIP_C);
    s1_rw  <= 13'(panels_per_row) * 13'(PANEL_COLS);
    s1_pan <= (panel_count > lpcf_pkg::CNT_W'(MAX_PANELS)) ?
              lpcf_pkg::CNT_W'(MAX_PANELS) : panel_count;
    // stage 2: local position, panel row base, serpentine distance
    s2_lr        <= lr_full[RW_W-1:0];
    s2_lc        <= lc_full[CW_W-1:0];
    s2_base      <= 17'(s1_qr) * 17'(panels_per_row);
    s2_odd       <= s1_qr[0];
    s2_col_out   <= 13'(col) >= s1_rw;
    s2_diff      <= diff_full[DW-1:0];
    s2_chain_out <= (10'(row) >= 10'(PANEL_ROWS)) ||
                    (13'(col) >= 13'(s1_pan) * 13'(PANEL_COLS));
    s2_qc        <= s1_qc;
    s2_pan       <= s1_pan;
    // stage 3: reversed panel offset, cross-axis quotients for rotation
    s3_qd        <= lpcf_pkg::recip_div(s2_diff, RECIP_C);
    s3_qlc       <= lpcf_pkg::recip_div(DW'(s2_lr), RECIP_C);
    s3_qlr       <= lpcf_pkg::recip_div(DW'(s2_lc), RECIP_R);
    s3_qc        <= s2_qc;
    s3_lr        <= s2_lr;
    s3_lc        <= s2_lc;
    s3_base      <= s2_base;
    s3_odd       <= s2_odd;
    s3_col_out   <= s2_col_out;
    s3_chain_out <= s2_chain_out;
    s3_pan       <= s2_pan;
    // stage 4: panel number and cross-axis remainders
    s4_panel     <= s3_base + 17'(s3_odd ? s3_qd : s3_qc);
    s4_lrc       <= lrc_full[CW_W-1:0];
    s4_lcr       <= lcr_full[RW_W-1:0];
    s4_lr        <= s3_lr;
    s4_lc        <= s3_lc;
    s4_col_out   <= s3_col_out;
    s4_chain_out <= s3_chain_out;
    s4_pan       <= s3_pan;
    // stage 5: rotate
    s5_nr      <= nr;
    s5_nc      <= nc;
    s5_pidx    <= pidx;
    s5_outside <= raw ? outside_g : s4_chain_out;
    // stage 6: chain column
    s6_brow    <= raw ? s5_nr : RW_W'(row);
    s6_bcol    <= raw ? (BC_W'(s5_nc) + BC_W'(s5_pidx) * BC_W'(PANEL_COLS)) : BC_W'(col);
    s6_outside <= s5_outside;
    // stage 7: linear address
    brow       <= s6_brow;
    bcol       <= s6_bcol;
    addr       <= AW'(s6_brow) * AW'(CHAIN_COLS) + AW'(s6_bcol);
    s7_outside <= s6_outside;
  end

  assign status = '{done: vld[STAGES], outside: s7_outside};

endmodule
`default_nettype wire

// ===== hdl/led_panel_chain_framebuffer.sv =====
// led_panel_chain_framebuffer: frame store for a serpentine chain of LED panels.
// Depends on lpcf_pkg, lpcf_map and lpcf_ram.
//
// Usage notes:
//  - Input channel (in_valid/in_ready) carries one command word: pixel write,
//    pixel read, clear dirty marks, or fill with fill_color. raw_flag=1 maps a
//    global row/col through the panel grid; raw_flag=0 uses a chain position.
//  - Output channel (out_valid/out_ready) returns exactly one result word per
//    command: read data and dirty mark on reads, mapped buffer_row/buffer_col on
//    reads and writes, status=1 when the position is off the chain.
//  - Config port (cfg_write/cfg_index/cfg_data) updates fill_color,
//    panel_count, panels_per_row, orientation_map; change only while idle.
//  - Pipeline: the address mapper is a 7-stage pipeline. The next word is
//    taken only once the previous result is in the output register; a read
//    also passes a RAM read state before its result is ready.
//  - Clear and fill sweep the store one entry per cycle, over all DEPTH
//    entries (8192 with default geometry), before the next word is taken.
//  - After reset the block clears color and dirty RAMs over all DEPTH entries,
//    one entry per cycle; in_ready stays low meanwhile, config writes still land.
//  - The result sits in an output register, so a new word is accepted while
//    the previous result waits; a stalled receiver only holds the next result.
`default_nettype none
module led_panel_chain_framebuffer #(
  parameter int PANEL_ROWS = lpcf_pkg::PANEL_ROWS_DEF,
  parameter int PANEL_COLS = lpcf_pkg::PANEL_COLS_DEF,
  parameter int MAX_PANELS = lpcf_pkg::MAX_PANELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // config
  input  wire logic                              cfg_write,
  input  wire logic [lpcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lpcf_pkg::OMAP_W-1:0]       cfg_data,
  // command in
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        command,
  input  wire logic                              raw_flag,
  input  wire logic [lpcf_pkg::POS_W-1:0]        row_in,
  input  wire logic [lpcf_pkg::POS_W-1:0]        col_in,
  input  wire logic [lpcf_pkg::COLOR_W-1:0]      pixel_color,
  // result out
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [lpcf_pkg::COLOR_W-1:0]      read_color,
  output logic                                   dirty_mark,
  output logic      [lpcf_pkg::OUT_ROW_W-1:0]    buffer_row,
  output logic      [lpcf_pkg::OUT_COL_W-1:0]    buffer_col,
  output logic                                   status
);

  localparam int RW_W       = $clog2(PANEL_ROWS);
  localparam int CHAIN_COLS = PANEL_COLS * MAX_PANELS;
  localparam int BC_W       = $clog2(CHAIN_COLS);
  localparam int DEPTH      = PANEL_ROWS * CHAIN_COLS;
  localparam int AW         = $clog2(DEPTH);

  // config registers
  logic [lpcf_pkg::COLOR_W-1:0] fill_color;
  logic [lpcf_pkg::CNT_W-1:0]   panel_count;
  logic [lpcf_pkg::CNT_W-1:0]   panels_per_row;
  logic [lpcf_pkg::OMAP_W-1:0]  orientation_map;

  // held command word
  lpcf_pkg::cmd_t               item_cmd;
  logic                         item_raw;
  logic [lpcf_pkg::POS_W-1:0]   item_row, item_col;
  logic [lpcf_pkg::COLOR_W-1:0] item_color;

  // pending result
  logic [lpcf_pkg::COLOR_W-1:0] res_color;
  logic                         res_dirty;
  logic [RW_W-1:0]              res_brow;
  logic [BC_W-1:0]              res_bcol;
  logic                         res_status;

  lpcf_pkg::state_t state, state_next;
  logic [AW-1:0]    sweep_addr;
  logic             sweep_last;
  logic             in_accept, out_free, map_start;
  lpcf_pkg::cmd_t   in_cmd;

  // mapper
  lpcf_pkg::map_status_t map_st;
  logic [RW_W-1:0] map_brow;
  logic [BC_W-1:0] map_bcol;
  logic [AW-1:0]   map_addr;

  // RAM ports
  logic                         frame_we, dirty_we;
  logic [AW-1:0]                waddr;
  logic [lpcf_pkg::COLOR_W-1:0] frame_wdata, frame_rdata;
  logic [0:0]                   dirty_wdata, dirty_rdata;

  // output field truncation
  logic [RW_W+lpcf_pkg::OUT_ROW_W-1:0] brow_ext;
  logic [BC_W+lpcf_pkg::OUT_COL_W-1:0] bcol_ext;

  assign in_cmd     = lpcf_pkg::cmd_t'(command);
  assign in_accept  = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign sweep_last = (sweep_addr == AW'(DEPTH - 1));
  assign map_start  = in_accept && ((in_cmd == lpcf_pkg::CMD_WRITE) ||
                                    (in_cmd == lpcf_pkg::CMD_READ));
  assign brow_ext   = (RW_W + lpcf_pkg::OUT_ROW_W)'(res_brow);
  assign bcol_ext   = (BC_W + lpcf_pkg::OUT_COL_W)'(res_bcol);

  lpcf_map #(
    .PANEL_ROWS (PANEL_ROWS),
    .PANEL_COLS (PANEL_COLS),
    .MAX_PANELS (MAX_PANELS)
  ) u_map (
    .clk             (clk),
    .rst             (rst),
    .start           (map_start),
    .raw             (item_raw),
    .row             (item_row),
    .col             (item_col),
    .panel_count     (panel_count),
    .panels_per_row  (panels_per_row),
    .orientation_map (orientation_map),
    .status          (map_st),
    .brow            (map_brow),
    .bcol            (map_bcol),
    .addr            (map_addr)
  );

  lpcf_ram #(
    .WIDTH (lpcf_pkg::COLOR_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (waddr),
    .wdata (frame_wdata),
    .raddr (map_addr),
    .rdata (frame_rdata)
  );

  lpcf_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_dirty_ram (
    .clk   (clk),
    .we    (dirty_we),
    .waddr (waddr),
    .wdata (dirty_wdata),
    .raddr (map_addr),
    .rdata (dirty_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lpcf_pkg::ST_INIT: begin
        if (sweep_last) state_next = lpcf_pkg::ST_IDLE;
      end
      lpcf_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (in_cmd)
            lpcf_pkg::CMD_CLEAR: state_next = lpcf_pkg::ST_CLEAR;
            lpcf_pkg::CMD_FILL:  state_next = lpcf_pkg::ST_FILL;
            default:             state_next = lpcf_pkg::ST_MAP;
          endcase
        end
      end
      lpcf_pkg::ST_MAP: begin
        if (map_st.done) begin
          if (!map_st.outside && (item_cmd == lpcf_pkg::CMD_READ)) begin
            state_next = lpcf_pkg::ST_READ;
          end else begin
            state_next = lpcf_pkg::ST_RESULT;
          end
        end
      end
      lpcf_pkg::ST_READ: state_next = lpcf_pkg::ST_RESULT;
      lpcf_pkg::ST_RESULT: begin
        if (out_free) state_next = lpcf_pkg::ST_IDLE;
      end
      lpcf_pkg::ST_CLEAR, lpcf_pkg::ST_FILL: begin
        if (sweep_last) state_next = lpcf_pkg::ST_RESULT;
      end
      default: state_next = lpcf_pkg::ST_IDLE;
    endcase
  end

  // RAM controls and ready
  always_comb begin
    in_ready    = (state == lpcf_pkg::ST_IDLE);
    frame_we    = 1'b0;
    dirty_we    = 1'b0;
    waddr       = sweep_addr;
    frame_wdata = '0;
    dirty_wdata = 1'b0;
    unique case (state)
      lpcf_pkg::ST_INIT: begin
        frame_we = 1'b1;
        dirty_we = 1'b1;
      end
      lpcf_pkg::ST_CLEAR: begin
        dirty_we = 1'b1;
      end
      lpcf_pkg::ST_FILL: begin
        frame_we    = 1'b1;
        frame_wdata = fill_color;
      end
      lpcf_pkg::ST_MAP: begin
        waddr = map_addr;
        if (map_st.done && !map_st.outside && (item_cmd == lpcf_pkg::CMD_WRITE)) begin
          frame_we    = 1'b1;
          dirty_we    = 1'b1;
          frame_wdata = item_color;
          dirty_wdata = 1'b1;
        end
      end
      default: begin
        frame_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= lpcf_pkg::ST_INIT;
      sweep_addr      <= '0;
      out_valid       <= 1'b0;
      fill_color      <= '0;
      panel_count     <= lpcf_pkg::CNT_W'(1);
      panels_per_row  <= lpcf_pkg::CNT_W'(1);
      orientation_map <= '0;
    end else begin
      state <= state_next;
      if ((state == lpcf_pkg::ST_INIT) || (state == lpcf_pkg::ST_CLEAR) ||
          (state == lpcf_pkg::ST_FILL)) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + AW'(1);
      end
      if ((state == lpcf_pkg::ST_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (lpcf_pkg::reg_t'(cfg_index))
          lpcf_pkg::REG_FILL_COLOR:     fill_color      <= cfg_data[lpcf_pkg::COLOR_W-1:0];
          lpcf_pkg::REG_PANEL_COUNT:    panel_count     <= cfg_data[lpcf_pkg::CNT_W-1:0];
          lpcf_pkg::REG_PANELS_PER_ROW: panels_per_row  <= cfg_data[lpcf_pkg::CNT_W-1:0];
          lpcf_pkg::REG_ORIENTATION:    orientation_map <= cfg_data;
          default:                      orientation_map <= orientation_map;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_cmd   <= in_cmd;
      item_raw   <= raw_flag;
      item_row   <= row_in;
      item_col   <= col_in;
      item_color <= pixel_color;
      res_color  <= '0;
      res_dirty  <= 1'b0;
      res_brow   <= '0;
      res_bcol   <= '0;
      res_status <= 1'b0;
    end
    if ((state == lpcf_pkg::ST_MAP) && map_st.done) begin
      res_status <= map_st.outside;
      if (!map_st.outside) begin
        res_brow <= map_brow;
        res_bcol <= map_bcol;
      end
    end
    if (state == lpcf_pkg::ST_READ) begin
      res_color <= frame_rdata;
      res_dirty <= dirty_rdata[0];
    end
    if ((state == lpcf_pkg::ST_RESULT) && out_free) begin
      read_color <= res_color;
      dirty_mark <= res_dirty;
      buffer_row <= brow_ext[lpcf_pkg::OUT_ROW_W-1:0];
      buffer_col <= bcol_ext[lpcf_pkg::OUT_COL_W-1:0];
      status     <= res_status;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_led_panel_chain_framebuffer.sv =====
// Self-checking bench for led_panel_chain_framebuffer: a table of directed probes, then
// random pixel traffic over several panel-grid setups, checked by an in-bench model or typed-in results.
// Depends on lpcf_pkg (types, codes, geometry) and the led_panel_chain_framebuffer RTL.
module tb_led_panel_chain_framebuffer;
  timeunit 1ns;
  timeprecision 1ps;
  import lpcf_pkg::*;

  // Geometry of the block as built (default parameters)
  localparam int ROWS_PER_PANEL = PANEL_ROWS_DEF;
  localparam int COLS_PER_PANEL = PANEL_COLS_DEF;
  localparam int CHAIN_PANELS   = MAX_PANELS_DEF;
  localparam int CHAIN_WIDTH    = COLS_PER_PANEL * CHAIN_PANELS;
  localparam int STORE_WORDS    = ROWS_PER_PANEL * CHAIN_WIDTH;
  localparam int POS_SPAN       = 1 << POS_W;

  localparam int NUM_PHASES    = 8;
  localparam int PHASE_WORDS   = 200;
  localparam int RECENT_DEPTH  = 16;
  localparam int MAX_GAP       = 40;
  // Fill and clear sweep the whole store, as does the clear after reset, and a
  // stalled receiver adds to that wait; the limit leaves ample room above a sweep.
  localparam int STALL_LIMIT   = 40000;
  localparam int SETTLE_CYCLES = 20;

  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_OFF_CHAIN = 1'b1;

  // One command word as sent on the input channel
  typedef struct packed {
    cmd_t                cmd;
    logic                raw;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic [COLOR_W-1:0]  color;
  } panel_cmd_t;

  // One result word as returned on the output channel
  typedef struct packed {
    logic [COLOR_W-1:0]   color;
    logic                 dirty;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 status;
  } pixel_result_t;

  // Directed probe: the word, and the result when it is typed in by hand
  typedef struct packed {
    panel_cmd_t    word;
    logic          typed;
    pixel_result_t result;
  } probe_t;

  // Directed probes run with fill 0xFFFFFF, 4 panels, 2 per grid row and the
  // orientation map 0xE4: panel 0 upright, 1 clockwise, 2 upside down, 3 ccw.
  localparam int NUM_PROBES = 23;
  localparam probe_t PROBES [NUM_PROBES] = '{
    // chain positions: store is all zero after reset
    '{'{CMD_READ,  1'b0, 9'd0,   9'd0,   24'h000000}, 1'b1, '{24'h000000, 1'b0, 4'd0,  9'd0,  STAT_OK}},
    '{'{CMD_WRITE, 1'b0, 9'd15,  9'd63,  24'hFFFFFF}, 1'b1, '{24'h000000, 1'b0, 4'd15, 9'd63, STAT_OK}},
    '{'{CMD_READ,  1'b0, 9'd15,  9'd63,  24'h000000}, 1'b1, '{24'hFFFFFF, 1'b1, 4'd15, 9'd63, STAT_OK}},
    // off the chain: row past the panel, column past the last panel, both at max
    '{'{CMD_WRITE, 1'b0, 9'd16,  9'd0,   24'h123456}, 1'b1, '{24'h000000, 1'b0, 4'd0,  9'd0,  STAT_OFF_CHAIN}},
    '{'{CMD_WRITE, 1'b0, 9'd0,   9'd64,  24'h654321}, 1'b1, '{24'h000000, 1'b0, 4'd0,  9'd0,  STAT_OFF_CHAIN}},
    '{'{CMD_READ,  1'b0, 9'd511, 9'd511, 24'h000000}, 1'b1, '{24'h000000, 1'b0, 4'd0,  9'd0,  STAT_OFF_CHAIN}},
    // global positions: every orientation hit, both serpentine directions
    '{'{CMD_WRITE, 1'b1, 9'd0,   9'd0,   24'h000001}, 1'b1, '{24'h000000, 1'b0, 4'd0,  9'd0,  STAT_OK}},
    '{'{CMD_WRITE, 1'b1, 9'd0,   9'd31,  24'hABCDEF}, 1'b0, '0},
    '{'{CMD_WRITE, 1'b1, 9'd16,  9'd0,   24'h00FF00}, 1'b0, '0},
    '{'{CMD_WRITE, 1'b1, 9'd16,  9'd31,  24'hFF0000}, 1'b0, '0},
    '{'{CMD_WRITE, 1'b1, 9'd31,  9'd17,  24'h0000FF}, 1'b0, '0},
    // global off the chain: past the row width, past the last panel, both at max
    '{'{CMD_WRITE, 1'b1, 9'd0,   9'd32,  24'h777777}, 1'b1, '{24'h000000, 1'b0, 4'd0,  9'd0,  STAT_OFF_CHAIN}},
    '{'{CMD_WRITE, 1'b1, 9'd32,  9'd0,   24'h888888}, 1'b1, '{24'h000000, 1'b0, 4'd0,  9'd0,  STAT_OFF_CHAIN}},
    '{'{CMD_READ,  1'b1, 9'd511, 9'd511, 24'h000000}, 1'b1, '{24'h000000, 1'b0, 4'd0,  9'd0,  STAT_OFF_CHAIN}},
    '{'{CMD_READ,  1'b1, 9'd16,  9'd0,   24'h000000}, 1'b0, '0},
    '{'{CMD_READ,  1'b1, 9'd0,   9'd31,  24'h000000}, 1'b0, '0},
    // clear drops dirty marks but keeps colors
    '{'{CMD_CLEAR, 1'b0, 9'd0,   9'd0,   24'h000000}, 1'b1, '{24'h000000, 1'b0, 4'd0,  9'd0,  STAT_OK}},
    '{'{CMD_READ,  1'b0, 9'd15,  9'd63,  24'h000000}, 1'b1, '{24'hFFFFFF, 1'b0, 4'd15, 9'd63, STAT_OK}},
    // fill overwrites colors and leaves dirty marks alone
    '{'{CMD_FILL,  1'b0, 9'd0,   9'd0,   24'h000000}, 1'b1, '{24'h000000, 1'b0, 4'd0,  9'd0,  STAT_OK}},
    '{'{CMD_READ,  1'b0, 9'd0,   9'd0,   24'h000000}, 1'b1, '{24'hFFFFFF, 1'b0, 4'd0,  9'd0,  STAT_OK}},
    '{'{CMD_WRITE, 1'b0, 9'd0,   9'd0,   24'h000000}, 1'b0, '0},
    '{'{CMD_READ,  1'b0, 9'd0,   9'd0,   24'h000000}, 1'b0, '0},
    '{'{CMD_READ,  1'b1, 9'd31,  9'd17,  24'h000000}, 1'b0, '0}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [OMAP_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           command;
  logic                 raw_flag;
  logic [POS_W-1:0]     row_in;
  logic [POS_W-1:0]     col_in;
  logic [COLOR_W-1:0]   pixel_color;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COLOR_W-1:0]   read_color;
  logic                 dirty_mark;
  logic [OUT_ROW_W-1:0] buffer_row;
  logic [OUT_COL_W-1:0] buffer_col;
  logic                 status;

  // Model copy of the store and of the registers
  logic [COLOR_W-1:0] frame_copy [STORE_WORDS];
  logic               dirty_copy [STORE_WORDS];
  logic [COLOR_W-1:0] fill_reg;
  logic [CNT_W-1:0]   count_reg;
  logic [CNT_W-1:0]   per_row_reg;
  logic [OMAP_W-1:0]  orient_reg;

  pixel_result_t pending_results [$];   // expected result words, oldest first
  panel_cmd_t    recent_writes [$];     // positions worth reading back

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int stall_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  led_panel_chain_framebuffer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .raw_flag    (raw_flag),
    .row_in      (row_in),
    .col_in      (col_in),
    .pixel_color (pixel_color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_color  (read_color),
    .dirty_mark  (dirty_mark),
    .buffer_row  (buffer_row),
    .buffer_col  (buffer_col),
    .status      (status)
  );

  // panel_count past the chain length saturates
  function automatic int active_panels();
    return (int'(count_reg) > CHAIN_PANELS) ? CHAIN_PANELS : int'(count_reg);
  endfunction

  // Map a position to the chain store; 0 when it falls off the chain
  function automatic bit map_to_chain(input logic raw, input int row, input int col,
                                      output int brow, output int bcol);
    int panels, width, grid_row, panel, lr, lc;
    panels = active_panels();
    brow = 0;
    bcol = 0;
    if (!raw) begin
      if (row >= ROWS_PER_PANEL || col >= COLS_PER_PANEL * panels) return 1'b0;
      brow = row;
      bcol = col;
      return 1'b1;
    end
    width = int'(per_row_reg) * COLS_PER_PANEL;
    if (col >= width) return 1'b0;
    grid_row = row / ROWS_PER_PANEL;
    panel = grid_row * int'(per_row_reg);
    // serpentine: odd grid rows run right to left
    if (grid_row % 2 == 1) panel += (width - 1 - col) / COLS_PER_PANEL;
    else panel += col / COLS_PER_PANEL;
    if (panel >= panels) return 1'b0;
    lr = row % ROWS_PER_PANEL;
    lc = col % COLS_PER_PANEL;
    case (orient_t'(orient_reg[2*panel +: 2]))
      ROT_CW: begin
        brow = lc % ROWS_PER_PANEL;
        bcol = COLS_PER_PANEL - 1 - (lr % COLS_PER_PANEL);
      end
      ROT_180: begin
        brow = ROWS_PER_PANEL - 1 - lr;
        bcol = COLS_PER_PANEL - 1 - lc;
      end
      ROT_CCW: begin
        brow = ROWS_PER_PANEL - 1 - (lc % ROWS_PER_PANEL);
        bcol = lr % COLS_PER_PANEL;
      end
      default: begin
        brow = lr;
        bcol = lc;
      end
    endcase
    bcol += COLS_PER_PANEL * panel;
    return 1'b1;
  endfunction

  // Apply one word to the model store and return the result word it gives
  function automatic pixel_result_t store_outcome(input panel_cmd_t w);
    pixel_result_t r;
    int brow, bcol, addr;
    r = '0;
    case (w.cmd)
      CMD_CLEAR: foreach (dirty_copy[i]) dirty_copy[i] = 1'b0;
      CMD_FILL:  foreach (frame_copy[i]) frame_copy[i] = fill_reg;
      default: begin
        if (!map_to_chain(w.raw, int'(w.row), int'(w.col), brow, bcol)) begin
          r.status = STAT_OFF_CHAIN;
        end else begin
          addr = brow * CHAIN_WIDTH + bcol;
          if (w.cmd == CMD_WRITE) begin
            frame_copy[addr] = w.color;
            dirty_copy[addr] = 1'b1;
          end else begin
            r.color = frame_copy[addr];
            r.dirty = dirty_copy[addr];
          end
          r.row    = OUT_ROW_W'(brow);
          r.col    = OUT_COL_W'(bcol);
          r.status = STAT_OK;
        end
      end
    endcase
    return r;
  endfunction

  // Mostly on-chain positions with random content; reads often revisit writes.
  // Fill and clear are rare since each one sweeps the whole store.
  function automatic panel_cmd_t random_word();
    panel_cmd_t w, prev;
    int pick, panels, grid_rows, row_span, col_span;
    pick  = $urandom_range(0, 199);
    w.raw = 1'($urandom_range(0, 1));
    w.row = POS_W'($urandom);
    w.col = POS_W'($urandom);
    case ($urandom_range(0, 7))
      0:       w.color = '0;
      1:       w.color = '1;
      default: w.color = COLOR_W'($urandom);
    endcase
    if (pick < 3) w.cmd = CMD_FILL;
    else if (pick < 6) w.cmd = CMD_CLEAR;
    else if (pick < 110) w.cmd = CMD_WRITE;
    else w.cmd = CMD_READ;
    panels = active_panels();
    if (w.cmd == CMD_READ && recent_writes.size() > 0 && $urandom_range(0, 1) == 1) begin
      prev  = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
      w.raw = prev.raw;
      w.row = prev.row;
      w.col = prev.col;
    end else if ($urandom_range(0, 9) != 0) begin
      if (!w.raw && panels > 0) begin
        w.row = POS_W'($urandom_range(0, ROWS_PER_PANEL - 1));
        w.col = POS_W'($urandom_range(0, COLS_PER_PANEL * panels - 1));
      end else if (w.raw && panels > 0 && per_row_reg != 0) begin
        grid_rows = (panels + int'(per_row_reg) - 1) / int'(per_row_reg);
        row_span  = ROWS_PER_PANEL * grid_rows;
        col_span  = COLS_PER_PANEL * int'(per_row_reg);
        if (row_span > POS_SPAN) row_span = POS_SPAN;
        if (col_span > POS_SPAN) col_span = POS_SPAN;
        w.row = POS_W'($urandom_range(0, row_span - 1));
        w.col = POS_W'($urandom_range(0, col_span - 1));
      end
    end
    if (w.cmd == CMD_WRITE) begin
      recent_writes.insert(recent_writes.size(), w);
      if (recent_writes.size() > RECENT_DEPTH) void'(recent_writes.pop_front());
    end
    return w;
  endfunction

  // One register write; the caller drops cfg_write after its last write.
  // Upper data bits carry junk that the block must ignore.
  task automatic write_reg(input reg_t idx, input logic [OMAP_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_FILL_COLOR:     fill_reg    = value[COLOR_W-1:0];
      REG_PANEL_COUNT:    count_reg   = value[CNT_W-1:0];
      REG_PANELS_PER_ROW: per_row_reg = value[CNT_W-1:0];
      default:            orient_reg  = value;
    endcase
  endtask

  task automatic program_setup(input logic [COLOR_W-1:0] fill, input logic [CNT_W-1:0] count,
                               input logic [CNT_W-1:0] per_row, input logic [OMAP_W-1:0] omap);
    logic [OMAP_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_FILL_COLOR, {junk[OMAP_W-COLOR_W-1:0], fill});
    write_reg(REG_PANEL_COUNT, {junk[OMAP_W-CNT_W-1:0], count});
    write_reg(REG_PANELS_PER_ROW, {junk[OMAP_W-CNT_W-1:0], per_row});
    write_reg(REG_ORIENTATION, omap);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Present one word, hold it until taken, then log the expected result.
  // Called in the time step of a clock edge; one nonblocking write per signal per step.
  task automatic send_word(input panel_cmd_t w, input logic typed, input pixel_result_t want);
    int gap;
    pixel_result_t model;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= w.cmd;
    raw_flag    <= w.raw;
    row_in      <= w.row;
    col_in      <= w.col;
    pixel_color <= w.color;
    do @(posedge clk); while (!in_ready);
    // model always runs so the store stays in step; typed rows override its answer
    model = store_outcome(w);
    pending_results.insert(pending_results.size(), typed ? want : model);
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Result side: check on accept, then pick next cycle's ready
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word expected none, actual status %0h color %0h",
                 $time, status, read_color);
      end else begin
        want = pending_results.pop_front();
        check_field("read_color", 32'(want.color), 32'(read_color));
        check_field("dirty_mark", 32'(want.dirty), 32'(dirty_mark));
        check_field("buffer_row", 32'(want.row), 32'(buffer_row));
        check_field("buffer_col", 32'(want.col), 32'(buffer_col));
        check_field("status", 32'(want.status), 32'(status));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int phase;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = REG_FILL_COLOR;
    cfg_data    = '0;
    in_valid    = 1'b0;
    command     = CMD_WRITE;
    raw_flag    = 1'b0;
    row_in      = '0;
    col_in      = '0;
    pixel_color = '0;
    // register and store state after reset
    fill_reg    = '0;
    count_reg   = CNT_W'(1);
    per_row_reg = CNT_W'(1);
    orient_reg  = '0;
    foreach (frame_copy[i]) begin
      frame_copy[i] = '0;
      dirty_copy[i] = 1'b0;
    end
    send_idle_pct = 36;
    recv_idle_pct = 86;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Writes land during the post-reset clear; words wait for in_ready
    program_setup(24'hFFFFFF, CNT_W'(4), CNT_W'(2), 64'hE4);
    for (int i = 0; i < NUM_PROBES; i++)
      send_word(PROBES[i].word, PROBES[i].typed, PROBES[i].result);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      in_valid <= 1'b0;
      wait_drain();
      case (phase)
        0: program_setup('0, CNT_W'(32), CNT_W'(32), {$urandom, $urandom});
        1: program_setup('1, CNT_W'(1), CNT_W'(1), '0);
        // panel_count past the chain length saturates
        2: program_setup(COLOR_W'($urandom), '1, CNT_W'(4), '1);
        // no panels at all: every position falls off the chain
        3: program_setup(COLOR_W'($urandom), '0, '1, {$urandom, $urandom});
        4: program_setup(COLOR_W'($urandom), CNT_W'(7), CNT_W'(3), {$urandom, $urandom});
        5: program_setup(COLOR_W'($urandom), CNT_W'(32), CNT_W'(5), {$urandom, $urandom});
        // zero panels per row: only chain positions land
        6: program_setup(COLOR_W'($urandom), CNT_W'(33), '0, {$urandom, $urandom});
        default: program_setup(COLOR_W'($urandom), CNT_W'($urandom_range(1, 32)),
                               CNT_W'($urandom_range(1, 32)), {$urandom, $urandom});
      endcase
      // slow receiver, then slow sender, then both at full rate
      send_idle_pct = (phase < 3) ? 36 : (phase < 6) ? 86 : 0;
      recv_idle_pct = (phase < 3) ? 86 : (phase < 6) ? 36 : 0;
      repeat (PHASE_WORDS) send_word(random_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lpcf_pkg.sv
hdl/lpcf_ram.sv
hdl/lpcf_map.sv
hdl/led_panel_chain_framebuffer.sv
tb/tb_led_panel_chain_framebuffer.sv
